>>> rtl/core/ivdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ivdq_pkg;

	localparam int LEVELS_DEF      = 8;
	localparam int QUEUE_DEPTH_DEF = 256;

	localparam int LEVEL_W  = 3;
	localparam int VEC_W    = 8;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	localparam logic [7:0] EN_RESET = 8'h7e;

	localparam logic [CMD_W-1:0] CMD_IRQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MASKED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ACFAIL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BUSERR = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd6;
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd7;

endpackage

`default_nettype wire

>>> rtl/core/interrupt_vector_dedup_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-level interrupt vector queue with duplicate suppression.
// The slave channel takes one command beat: tuser holds the command (interrupt event,
// read oldest vector, poll and re-arm) and tdata holds level, vector and the bus error flag.
// The master channel returns exactly one result beat per command beat: tuser holds the
// status code and tdata holds the popped vector, the not-empty flag and the wake flag.
// An accepted beat is registered into the command stage and then into the result register,
// which drives the master channel; with the master side ready the block takes a new beat
// every cycle. The rate is set by one registered read and one write of the vector and
// presence memories per beat, with forwarding between back-to-back beats.
// After reset the presence memory is cleared one entry per cycle, all LEVELS * 256 entries,
// and s_tready stays low until that pass ends. Enable bits come up for levels one to six.
// When the receiver stalls, the result register holds its beat, the stage before it holds
// its command, and s_tready drops once both are occupied.
module interrupt_vector_dedup_queue_core #(
	parameter int LEVELS      = ivdq_pkg::LEVELS_DEF,
	parameter int QUEUE_DEPTH = ivdq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// level[2:0], vector[10:3], bus_error[11], zero fill[15:12]
	input  wire logic [ivdq_pkg::S_DATA_W-1:0]       s_tdata,
	// cmd[1:0]
	input  wire logic [ivdq_pkg::CMD_W-1:0]          s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// vector_out[7:0], not_empty[8], wake[9], zero fill[15:10]
	output logic [ivdq_pkg::M_DATA_W-1:0]            m_tdata,
	// status[2:0]
	output logic [ivdq_pkg::STATUS_W-1:0]            m_tuser
);

	localparam int VEC_W      = ivdq_pkg::VEC_W;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int QW         = $clog2(QUEUE_DEPTH);
	localparam int PA_W       = LVL_W + VEC_W;
	localparam int VA_W       = LVL_W + QW;
	localparam int PRES_DEPTH = LEVELS * (2 ** VEC_W);
	localparam int VS_DEPTH   = LEVELS * (2 ** QW);
	localparam logic [PA_W-1:0] PA_LAST = PA_W'(PRES_DEPTH - 1);

	function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] i);
		ring_next = (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [VEC_W-1:0] vs_mem   [VS_DEPTH];
	logic             pres_mem [PRES_DEPTH];

	logic [LEVELS-1:0] en_q;
	logic [QW-1:0]     wr_q [LEVELS];
	logic [QW-1:0]     rd_q [LEVELS];
	logic              clr_busy_q;
	logic [PA_W-1:0]   clr_cnt_q;

	logic                          vld_s1;
	logic [ivdq_pkg::CMD_W-1:0]    cmd_s1;
	logic [ivdq_pkg::LEVEL_W-1:0]  level_s1;
	logic [VEC_W-1:0]              vector_s1;
	logic                          berr_s1;
	logic                          pres_rd_s1;
	logic [VEC_W-1:0]              vs_rd_s1;
	logic                          pres_fwd_s1;
	logic                          pres_fwd_val_s1;
	logic                          vs_fwd_s1;
	logic [VEC_W-1:0]              vs_fwd_val_s1;

	logic                          vld_s2;
	logic [ivdq_pkg::STATUS_W-1:0] status_s2;
	logic [VEC_W-1:0]              vout_s2;
	logic                          ne_s2;
	logic                          wake_s2;

	logic [ivdq_pkg::LEVEL_W-1:0] in_level;
	logic [VEC_W-1:0]             in_vector;
	logic                         in_lv_ok;
	logic [LVL_W-1:0]             in_lv;
	logic                         s_fire;
	logic                         s1_adv;

	logic                          lv_ok;
	logic [LVL_W-1:0]              lv;
	logic [QW-1:0]                 wr_cur;
	logic [QW-1:0]                 rd_cur;
	logic [QW-1:0]                 wr_nx;
	logic [QW-1:0]                 rd_nx;
	logic                          en_cur;
	logic                          has;
	logic                          full;
	logic                          pres_bit;
	logic [VEC_W-1:0]              vdat;
	logic [ivdq_pkg::STATUS_W-1:0] status;
	logic [VEC_W-1:0]              vout;
	logic                          ne;
	logic                          wake;
	logic                          do_enq;
	logic                          do_pop;
	logic                          en_clr;
	logic                          en_set;

	logic [LEVELS-1:0] en_d;
	logic [QW-1:0]     wr_d [LEVELS];
	logic [QW-1:0]     rd_d [LEVELS];

	logic             pres_we;
	logic [PA_W-1:0]  pres_wa;
	logic             pres_wd;
	logic             vs_we;
	logic [VA_W-1:0]  vs_wa;
	logic [PA_W-1:0]  pa_in;
	logic [VA_W-1:0]  va_in;

	assign in_level  = s_tdata[2:0];
	assign in_vector = s_tdata[10:3];
	assign in_lv_ok  = 32'(in_level) < 32'(LEVELS);
	assign in_lv     = in_lv_ok ? in_level[LVL_W-1:0] : '0;

	assign s1_adv   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !clr_busy_q && (!vld_s1 || s1_adv);
	assign s_fire   = s_tvalid && s_tready;

	always_comb begin
		lv_ok    = 32'(level_s1) < 32'(LEVELS);
		lv       = lv_ok ? level_s1[LVL_W-1:0] : '0;
		wr_cur   = wr_q[lv];
		rd_cur   = rd_q[lv];
		en_cur   = en_q[lv] && lv_ok;
		has      = wr_cur != rd_cur;
		wr_nx    = ring_next(wr_cur);
		rd_nx    = ring_next(rd_cur);
		full     = wr_nx == rd_cur;
		pres_bit = pres_fwd_s1 ? pres_fwd_val_s1 : pres_rd_s1;
		vdat     = vs_fwd_s1 ? vs_fwd_val_s1 : vs_rd_s1;

		status = ivdq_pkg::ST_OK;
		vout   = '0;
		wake   = 1'b0;
		do_enq = 1'b0;
		do_pop = 1'b0;
		en_clr = 1'b0;
		en_set = 1'b0;

		case (cmd_s1)
			ivdq_pkg::CMD_IRQ: begin
				if (!en_cur) begin
					status = ivdq_pkg::ST_MASKED;
				end else begin
					en_clr = 1'b1;
					wake   = 1'b1;
					if (level_s1 == '0) begin
						status = ivdq_pkg::ST_ACFAIL;
					end else if (berr_s1) begin
						status = ivdq_pkg::ST_BUSERR;
					end else if (pres_bit) begin
						status = ivdq_pkg::ST_DUP;
					end else if (full) begin
						status = ivdq_pkg::ST_FULL;
					end else begin
						do_enq = 1'b1;
						status = ivdq_pkg::ST_QUEUED;
					end
				end
			end
			ivdq_pkg::CMD_READ: begin
				if (!lv_ok || !has) begin
					status = ivdq_pkg::ST_EMPTY;
				end else begin
					do_pop = 1'b1;
					vout   = vdat;
				end
			end
			ivdq_pkg::CMD_POLL: begin
				en_set = lv_ok;
			end
			default: begin
			end
		endcase

		if (!lv_ok) begin
			ne = 1'b0;
		end else if (do_enq) begin
			ne = 1'b1;
		end else if (do_pop) begin
			ne = rd_nx != wr_cur;
		end else begin
			ne = has;
		end
	end

	always_comb begin
		en_d = en_q;
		for (int i = 0; i < LEVELS; i++) begin
			wr_d[i] = wr_q[i];
			rd_d[i] = rd_q[i];
		end
		if (s1_adv && do_enq) begin
			wr_d[lv] = wr_nx;
		end
		if (s1_adv && do_pop) begin
			rd_d[lv] = rd_nx;
		end
		if (s1_adv && en_clr) begin
			en_d[lv] = 1'b0;
		end
		if (s1_adv && en_set) begin
			en_d[lv] = 1'b1;
		end
	end

	assign pres_we = clr_busy_q || (s1_adv && (do_enq || do_pop));
	assign pres_wa = clr_busy_q ? clr_cnt_q : {lv, (do_enq ? vector_s1 : vdat)};
	assign pres_wd = !clr_busy_q && do_enq;
	assign vs_we   = s1_adv && do_enq;
	assign vs_wa   = {lv, wr_cur};
	assign pa_in   = {in_lv, in_vector};
	assign va_in   = {in_lv, rd_d[in_lv]};

	always_ff @(posedge clk) begin
		if (pres_we) begin
			pres_mem[pres_wa] <= pres_wd;
		end
		if (s_fire) begin
			pres_rd_s1 <= pres_mem[pa_in];
		end
	end

	always_ff @(posedge clk) begin
		if (vs_we) begin
			vs_mem[vs_wa] <= vector_s1;
		end
		if (s_fire) begin
			vs_rd_s1 <= vs_mem[va_in];
		end
	end

	// A write committed at the same edge as the next read is forwarded to that read.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1          <= s_tuser;
			level_s1        <= in_level;
			vector_s1       <= in_vector;
			berr_s1         <= s_tdata[11];
			pres_fwd_s1     <= pres_we && (pres_wa == pa_in);
			pres_fwd_val_s1 <= pres_wd;
			vs_fwd_s1       <= vs_we && (vs_wa == va_in);
			vs_fwd_val_s1   <= vector_s1;
		end
		if (s1_adv) begin
			status_s2 <= status;
			vout_s2   <= vout;
			ne_s2     <= ne;
			wake_s2   <= wake;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			en_q       <= ivdq_pkg::EN_RESET[LEVELS-1:0];
			for (int i = 0; i < LEVELS; i++) begin
				wr_q[i] <= '0;
				rd_q[i] <= '0;
			end
		end else begin
			if (s_fire) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
			if (clr_busy_q) begin
				if (clr_cnt_q == PA_LAST) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end
			en_q <= en_d;
			for (int i = 0; i < LEVELS; i++) begin
				wr_q[i] <= wr_d[i];
				rd_q[i] <= rd_d[i];
			end
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {6'b0, wake_s2, ne_s2, vout_s2};
	assign m_tuser  = status_s2;

endmodule

`default_nettype wire

>>> rtl/core/ivdq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ivdq_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [ivdq_pkg::M_DATA_W-1:0] m_tdata,
	input wire logic [ivdq_pkg::STATUS_W-1:0] m_tuser
);

	// A stalled result beat must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Only a successful read carries a vector.
	a_vout: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ivdq_pkg::ST_OK) |-> (m_tdata[7:0] == 8'd0))
		else $error("vector on a result that is not a successful read");

	// Wake comes only from a taken interrupt.
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |->
			(m_tuser == ivdq_pkg::ST_QUEUED) || (m_tuser == ivdq_pkg::ST_ACFAIL) ||
			(m_tuser == ivdq_pkg::ST_BUSERR) || (m_tuser == ivdq_pkg::ST_DUP) ||
			(m_tuser == ivdq_pkg::ST_FULL))
		else $error("wake without a taken interrupt");

	// A queued vector leaves the queue non-empty, an empty read leaves it empty.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			((m_tuser != ivdq_pkg::ST_QUEUED) || m_tdata[8]) &&
			((m_tuser != ivdq_pkg::ST_EMPTY) || !m_tdata[8]))
		else $error("not-empty flag disagrees with status");

endmodule

bind interrupt_vector_dedup_queue_core ivdq_checker u_ivdq_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ivdq_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 160;
	localparam logic [LEVEL_W-1:0] FILL_LEVEL = 3'd5;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VEC_W-1:0]    vector_out;
		logic                not_empty;
		logic                wake;
	} irq_result_t;

	class irq_queue_tracker;
		logic [7:0] armed;
		logic [VEC_W-1:0] slot [LEVELS_DEF][QUEUE_DEPTH_DEF];
		bit waiting [LEVELS_DEF][256];
		logic [7:0] wr_ptr [LEVELS_DEF];
		logic [7:0] rd_ptr [LEVELS_DEF];
		irq_result_t due_results[$];
		int errors;

		function new();
			armed = EN_RESET;
			errors = 0;
			for (int l = 0; l < LEVELS_DEF; l++) begin
				wr_ptr[l] = '0;
				rd_ptr[l] = '0;
				for (int v = 0; v < 256; v++) begin
					waiting[l][v] = 1'b0;
					slot[l][v] = '0;
				end
			end
		endfunction

		function void take_command(logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] lvl,
				logic [VEC_W-1:0] vec, logic berr);
			irq_result_t r;
			logic [VEC_W-1:0] popped;
			r.status = ST_OK;
			r.vector_out = '0;
			r.not_empty = 1'b0;
			r.wake = 1'b0;
			case (cmd)
				CMD_IRQ: begin
					if (!armed[lvl]) begin
						r.status = ST_MASKED;
					end else begin
						armed[lvl] = 1'b0;
						r.wake = 1'b1;
						if (lvl == '0) begin
							r.status = ST_ACFAIL;
						end else if (berr) begin
							r.status = ST_BUSERR;
						end else if (waiting[lvl][vec]) begin
							r.status = ST_DUP;
						end else if (8'(wr_ptr[lvl] + 8'd1) == rd_ptr[lvl]) begin
							r.status = ST_FULL;
						end else begin
							slot[lvl][wr_ptr[lvl]] = vec;
							wr_ptr[lvl] = 8'(wr_ptr[lvl] + 8'd1);
							waiting[lvl][vec] = 1'b1;
							r.status = ST_QUEUED;
						end
					end
				end
				CMD_READ: begin
					if (wr_ptr[lvl] == rd_ptr[lvl]) begin
						r.status = ST_EMPTY;
					end else begin
						popped = slot[lvl][rd_ptr[lvl]];
						rd_ptr[lvl] = 8'(rd_ptr[lvl] + 8'd1);
						waiting[lvl][popped] = 1'b0;
						r.vector_out = popped;
						r.status = ST_OK;
					end
				end
				CMD_POLL: begin
					armed[lvl] = 1'b1;
				end
				default: begin
				end
			endcase
			r.not_empty = (wr_ptr[lvl] != rd_ptr[lvl]);
			due_results.push_back(r);
		endfunction

		function void match_result(irq_result_t got);
			irq_result_t want;
			if (due_results.size() == 0) begin
				$error("result beat with no command waiting: status %0d", got.status);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.vector_out !== want.vector_out) begin
				$error("vector_out mismatch: expected %0d, actual %0d",
					want.vector_out, got.vector_out);
				errors++;
			end
			if (got.not_empty !== want.not_empty) begin
				$error("not_empty mismatch: expected %0d, actual %0d",
					want.not_empty, got.not_empty);
				errors++;
			end
			if (got.wake !== want.wake) begin
				$error("wake mismatch: expected %0d, actual %0d", want.wake, got.wake);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	irq_queue_tracker tracker;
	int beats_sent;
	int burst_left;
	bit long_hold_done;

	interrupt_vector_dedup_queue_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	task automatic send_command(logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] lvl,
			logic [VEC_W-1:0] vec, logic berr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W - LEVEL_W - VEC_W - 1){1'b0}}, berr, vec, lvl};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		tracker.take_command(cmd, lvl, vec, berr);
		beats_sent++;
	endtask

	task automatic arm_and_raise(logic [LEVEL_W-1:0] lvl, logic [VEC_W-1:0] vec, logic berr);
		send_command(CMD_POLL, lvl, VEC_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_command(CMD_IRQ, lvl, vec, berr);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.match_result({m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9]});
		end
	end

	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				if (!long_hold_done && beats_sent >= 300) begin
					long_hold_done = 1'b1;
					m_tready <= 1'b0;
					repeat (400) @(negedge clk);
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= ($urandom_range(0, 1) == 1);
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin
		int pick;
		logic [LEVEL_W-1:0] lvl;
		tracker = new();
		beats_sent = 0;
		burst_left = 0;
		long_hold_done = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_IRQ;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_command(CMD_IRQ, 3'd0, 8'h12, 1'b0);
		send_command(CMD_IRQ, 3'd7, 8'hff, 1'b1);
		send_command(CMD_POLL, 3'd0, 8'h00, 1'b0);
		send_command(CMD_IRQ, 3'd0, 8'h34, 1'b1);
		send_command(CMD_READ, 3'd3, 8'h00, 1'b0);
		send_command(CMD_IRQ, 3'd1, 8'h00, 1'b0);
		send_command(CMD_IRQ, 3'd1, 8'h01, 1'b0);
		arm_and_raise(3'd1, 8'h00, 1'b0);
		arm_and_raise(3'd1, 8'hff, 1'b1);
		arm_and_raise(3'd1, 8'hff, 1'b0);
		send_command(CMD_READ, 3'd1, 8'hff, 1'b1);
		send_command(CMD_READ, 3'd1, 8'h00, 1'b0);
		send_command(CMD_READ, 3'd1, 8'h00, 1'b0);
		send_command(2'd3, 3'd1, 8'hff, 1'b1);
		send_command(2'd3, 3'd7, 8'h00, 1'b0);
		arm_and_raise(3'd7, 8'haa, 1'b0);
		send_command(CMD_IRQ, 3'd6, 8'h55, 1'b0);
		send_command(CMD_READ, 3'd7, 8'h00, 1'b0);
		send_command(CMD_READ, 3'd6, 8'h00, 1'b0);

		// Fill one ring to its last usable slot, overflow it, then drain most of it.
		for (int v = 0; v < 256; v++) begin
			arm_and_raise(FILL_LEVEL, VEC_W'(v), 1'b0);
		end
		arm_and_raise(FILL_LEVEL, 8'h03, 1'b0);
		for (int i = 0; i < 200; i++) begin
			send_command(CMD_READ, FILL_LEVEL, VEC_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		end

		beats_sent = 0;
		while (beats_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			lvl = LEVEL_W'($urandom_range(0, 7));
			if (pick < 60) begin
				arm_and_raise(lvl,
					($urandom_range(0, 1) == 1) ? VEC_W'($urandom_range(0, 15))
						: VEC_W'($urandom_range(0, 255)),
					($urandom_range(0, 9) == 0));
			end else if (pick < 85) begin
				send_command(CMD_READ, lvl, VEC_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				send_command(CMD_W'($urandom_range(0, 3)), lvl, VEC_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
